### src/sam_pkg.sv
// Shared types, register indexes and helpers for the stacked alpha mask combiner.
// No dependencies; every other file but sam_if imports this package.
package sam_pkg;

	localparam int CFG_W = 14;
	localparam int IDX_W = 3;

	localparam logic [IDX_W-1:0] REG_INVERSE  = 3'd0;
	localparam logic [IDX_W-1:0] REG_OUT_OPAC = 3'd1;
	localparam logic [IDX_W-1:0] REG_WIDTH    = 3'd2;
	localparam logic [IDX_W-1:0] REG_HEIGHT   = 3'd3;
	localparam logic [IDX_W-1:0] REG_LEFT     = 3'd4;
	localparam logic [IDX_W-1:0] REG_TOP      = 3'd5;
	localparam logic [IDX_W-1:0] REG_RIGHT    = 3'd6;
	localparam logic [IDX_W-1:0] REG_BOTTOM   = 3'd7;

	localparam logic [7:0] ALPHA_MAX = 8'd255;

	typedef struct packed {
		logic        inverse;
		logic [7:0]  outside_opacity;
		logic [12:0] mask_width;
		logic [12:0] mask_height;
		logic [13:0] region_left;
		logic [13:0] region_top;
		logic [13:0] region_right;
		logic [13:0] region_bottom;
	} cfg_t;

	typedef struct packed {
		logic in_region;
		logic row_end;
		logic mask_end;
	} pos_t;

	typedef struct packed {
		logic [7:0] alpha;
		logic [7:0] factor;
		logic       row_end;
		logic       mask_end;
	} blend_t;

	// floor(x / 255) for any product of two bytes (x up to 255 * 255)
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [16:0] t;
		begin
			t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
			div255 = t[15:8];
		end
	endfunction

endpackage

### src/sam_if.sv
// Valid/ready channel interfaces for input and result words.
// Depends on nothing.
interface sam_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] source_alpha;
	logic [7:0] prev_alpha;
	modport source(output valid, source_alpha, prev_alpha, input ready);
	modport sink(input valid, source_alpha, prev_alpha, output ready);
endinterface

interface sam_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] mask_alpha;
	logic       row_end;
	logic       mask_end;
	modport source(output valid, mask_alpha, row_end, mask_end, input ready);
	modport sink(input valid, mask_alpha, row_end, mask_end, output ready);
endinterface

### src/stacked_alpha_mask_combine.sv
// Stacked alpha mask combiner, top level: config, position, input and result registers.
// Depends on sam_pkg, sam_if, sam_cfg, sam_pos and sam_blend.
//
//   channel   dir   word
//   pix_in    in    source_alpha, prev_alpha
//   pix_out   out   mask_alpha, row_end, mask_end
//   cfg_*     in    write enable, register index, data
//
// One word per cycle sustained while the output is ready; two registers (input register, result register).
// Counters and control clear on arst_n; config writes never touch the counters.
// A stalled output holds its word while one more word waits in the input register.
module stacked_alpha_mask_combine #(
	parameter int MAX_DIM = 4096
) (
	input  logic                       clk,
	input  logic                       arst_n,
	sam_in_if.sink                     pix_in,
	sam_out_if.source                  pix_out,
	input  logic                       cfg_we,
	input  logic [sam_pkg::IDX_W-1:0]  cfg_index,
	input  logic [sam_pkg::CFG_W-1:0]  cfg_data
);
	import sam_pkg::*;

	cfg_t   cfg;
	pos_t   pos;
	blend_t data_s1;
	logic   valid_s1;
	logic   take;
	logic   accept;
	logic [7:0] alpha_in;

	sam_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	sam_pos #(.MAX_DIM(MAX_DIM)) u_pos (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.step   (accept),
		.pos    (pos)
	);

	assign pix_in.ready = !valid_s1 || take;
	assign accept       = pix_in.valid && pix_in.ready;
	assign alpha_in     = cfg.inverse ? ALPHA_MAX - pix_in.source_alpha : pix_in.source_alpha;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (pix_in.ready)
			valid_s1 <= pix_in.valid;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1.alpha    <= alpha_in;
			data_s1.factor   <= pos.in_region ? pix_in.prev_alpha : cfg.outside_opacity;
			data_s1.row_end  <= pos.row_end;
			data_s1.mask_end <= pos.mask_end;
		end
	end

	sam_blend u_blend (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1),
		.take     (take),
		.pix_out  (pix_out)
	);
endmodule

### src/sam_cfg.sv
// Configuration register file of the stacked alpha mask combiner.
// Depends on sam_pkg.
module sam_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [sam_pkg::IDX_W-1:0]  cfg_index,
	input  logic [sam_pkg::CFG_W-1:0]  cfg_data,
	output sam_pkg::cfg_t              cfg
);
	import sam_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.inverse         <= 1'b0;
			cfg_q.outside_opacity <= ALPHA_MAX;
			cfg_q.mask_width      <= 13'd1;
			cfg_q.mask_height     <= 13'd1;
			cfg_q.region_left     <= 14'd0;
			cfg_q.region_top      <= 14'd0;
			cfg_q.region_right    <= 14'h3FFF;
			cfg_q.region_bottom   <= 14'h3FFF;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_INVERSE:  cfg_q.inverse         <= cfg_data[0];
				REG_OUT_OPAC: cfg_q.outside_opacity <= cfg_data[7:0];
				REG_WIDTH:    cfg_q.mask_width      <= cfg_data[12:0];
				REG_HEIGHT:   cfg_q.mask_height     <= cfg_data[12:0];
				REG_LEFT:     cfg_q.region_left     <= cfg_data;
				REG_TOP:      cfg_q.region_top      <= cfg_data;
				REG_RIGHT:    cfg_q.region_right    <= cfg_data;
				REG_BOTTOM:   cfg_q.region_bottom   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule

### src/sam_pos.sv
// Raster position tracker: column/row counters, region test, row and mask end.
// Depends on sam_pkg.
module sam_pos #(
	parameter int MAX_DIM = 4096
) (
	input  logic          clk,
	input  logic          arst_n,
	input  sam_pkg::cfg_t cfg,
	input  logic          step,
	output sam_pkg::pos_t pos
);
	import sam_pkg::*;

	localparam int CW = $clog2(MAX_DIM);
	localparam logic [13:0] DIM_MAX = 14'(MAX_DIM);

	logic [CW-1:0] col_q, row_q;
	logic [13:0]   w_clamp, h_clamp, last_col, last_row;
	logic signed [15:0] px, py, right_x, bottom_y;
	logic row_end, mask_end;

	always_comb begin
		w_clamp = {1'b0, cfg.mask_width};
		if (w_clamp == 14'd0)
			w_clamp = 14'd1;
		else if (w_clamp > DIM_MAX)
			w_clamp = DIM_MAX;
		h_clamp = {1'b0, cfg.mask_height};
		if (h_clamp == 14'd0)
			h_clamp = 14'd1;
		else if (h_clamp > DIM_MAX)
			h_clamp = DIM_MAX;
	end

	assign last_col = w_clamp - 14'd1;
	assign last_row = h_clamp - 14'd1;
	assign row_end  = {{(14-CW){1'b0}}, col_q} >= last_col;
	assign mask_end = row_end && ({{(14-CW){1'b0}}, row_q} >= last_row);

	assign px = {{2{cfg.region_left[13]}}, cfg.region_left} + {{(16-CW){1'b0}}, col_q};
	assign py = {{2{cfg.region_top[13]}}, cfg.region_top} + {{(16-CW){1'b0}}, row_q};
	assign right_x  = {{2{cfg.region_right[13]}}, cfg.region_right};
	assign bottom_y = {{2{cfg.region_bottom[13]}}, cfg.region_bottom};

	assign pos.in_region = !px[15] && !py[15] && (px <= right_x) && (py <= bottom_y);
	assign pos.row_end   = row_end;
	assign pos.mask_end  = mask_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (step) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= mask_end ? '0 : row_q + CW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end
endmodule

### src/sam_blend.sv
// Result stage: alpha times factor, divided by 255, held in the output register.
// Depends on sam_pkg and sam_if.
module sam_blend (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid_s1,
	input  sam_pkg::blend_t   data_s1,
	output logic              take,
	sam_out_if.source         pix_out
);
	import sam_pkg::*;

	logic        valid_q;
	logic [7:0]  alpha_q;
	logic        row_end_q, mask_end_q;
	logic [15:0] prod;

	assign take = !valid_q || pix_out.ready;
	assign prod = 16'(data_s1.alpha) * 16'(data_s1.factor);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (take)
			valid_q <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (take && valid_s1) begin
			alpha_q    <= div255(prod);
			row_end_q  <= data_s1.row_end;
			mask_end_q <= data_s1.mask_end;
		end
	end

	assign pix_out.valid      = valid_q;
	assign pix_out.mask_alpha = alpha_q;
	assign pix_out.row_end    = row_end_q;
	assign pix_out.mask_end   = mask_end_q;
endmodule

### sim/stacked_alpha_mask_combine_test.sv
// Self-checking bench for stacked_alpha_mask_combine: mirrors the register file and the
// raster counters, predicts every mask word and checks the result stream in order.
// Depends on sam_pkg, sam_if and the block's RTL.
module stacked_alpha_mask_combine_test;
	import sam_pkg::*;

	localparam int MAX_DIM = 4096;
	localparam int LATENCY = 2;
	localparam int LONG_HOLD = 300;
	localparam int MAX_REPORTS = 200;

	typedef struct packed {
		logic [7:0] source_alpha;
		logic [7:0] prev_alpha;
	} pixel_t;

	typedef struct packed {
		logic [7:0] alpha;
		logic       row_end;
		logic       mask_end;
	} mask_word_t;

	typedef enum int {FLOW_FREE, FLOW_SEND_GAPS, FLOW_RECV_STALLS, FLOW_BOTH} flow_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	sam_in_if  in_ch();
	sam_out_if out_ch();

	pixel_t     pending_pixels[$];
	mask_word_t expected_words[$];
	mask_word_t head_word;
	mask_word_t got_word;
	cfg_t       mask_regs;
	int         col_pos = 0;
	int         row_pos = 0;
	int         send_idle_pct = 0;
	int         recv_stall_pct = 0;
	int         hold_requests = 0;
	int         hold_served = 0;
	int         hold_left = 0;
	int         errors = 0;

	stacked_alpha_mask_combine #(.MAX_DIM(MAX_DIM)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.pix_in(in_ch),
		.pix_out(out_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	function automatic int clip_dim(logic [12:0] d);
		if (d == 0)
			return 1;
		if (d > MAX_DIM)
			return MAX_DIM;
		return int'(d);
	endfunction

	// advances the raster position as a side effect
	function automatic mask_word_t combine_pixel(pixel_t pix);
		int         w;
		int         h;
		int         px;
		int         py;
		logic [7:0] a;
		logic [7:0] factor;
		logic       in_region;
		mask_word_t r;
		w = clip_dim(mask_regs.mask_width);
		h = clip_dim(mask_regs.mask_height);
		a = mask_regs.inverse ? ALPHA_MAX - pix.source_alpha : pix.source_alpha;
		px = int'($signed(mask_regs.region_left)) + col_pos;
		py = int'($signed(mask_regs.region_top)) + row_pos;
		in_region = px >= 0 && px <= int'($signed(mask_regs.region_right)) &&
			py >= 0 && py <= int'($signed(mask_regs.region_bottom));
		factor = in_region ? pix.prev_alpha : mask_regs.outside_opacity;
		r.alpha = 8'((16'(a) * 16'(factor)) / 16'd255);
		r.row_end = col_pos >= w - 1;
		r.mask_end = r.row_end && row_pos >= h - 1;
		if (r.row_end) begin
			col_pos = 0;
			row_pos = r.mask_end ? 0 : row_pos + 1;
		end else begin
			col_pos = col_pos + 1;
		end
		return r;
	endfunction

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.source_alpha <= '0;
			in_ch.prev_alpha <= '0;
		end else begin
			if (in_ch.valid && in_ch.ready)
				expected_words.push_back(
					combine_pixel(pixel_t'({in_ch.source_alpha, in_ch.prev_alpha})));
			if (!in_ch.valid || in_ch.ready) begin
				if (pending_pixels.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_ch.valid <= 1'b1;
					{in_ch.source_alpha, in_ch.prev_alpha} <= pending_pixels.pop_front();
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// receiver and checker
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			hold_left <= 0;
			hold_served <= 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				got_word = mask_word_t'({out_ch.mask_alpha, out_ch.row_end, out_ch.mask_end});
				if (expected_words.size() == 0) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("%0t: unexpected word: expected none, got alpha %0d row_end %b mask_end %b",
							$time, got_word.alpha, got_word.row_end, got_word.mask_end);
				end else begin
					head_word = expected_words.pop_front();
					if (got_word !== head_word) begin
						errors++;
						if (errors <= MAX_REPORTS)
							$display("%0t: mismatch: expected alpha %0d row_end %b mask_end %b, got alpha %0d row_end %b mask_end %b",
								$time, head_word.alpha, head_word.row_end, head_word.mask_end,
								got_word.alpha, got_word.row_end, got_word.mask_end);
					end
				end
			end
			if (hold_served != hold_requests) begin
				hold_served <= hold_requests;
				hold_left <= LONG_HOLD;
				out_ch.ready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= $urandom_range(99) >= recv_stall_pct;
			end
		end
	end

	task automatic set_flow(flow_t mode);
		case (mode)
			FLOW_FREE: begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			FLOW_SEND_GAPS: begin
				send_idle_pct = 48;
				recv_stall_pct = 0;
			end
			FLOW_RECV_STALLS: begin
				send_idle_pct = 0;
				recv_stall_pct = 48;
			end
			default: begin
				send_idle_pct = 25;
				recv_stall_pct = 25;
			end
		endcase
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			REG_INVERSE:  mask_regs.inverse = data[0];
			REG_OUT_OPAC: mask_regs.outside_opacity = data[7:0];
			REG_WIDTH:    mask_regs.mask_width = data[12:0];
			REG_HEIGHT:   mask_regs.mask_height = data[12:0];
			REG_LEFT:     mask_regs.region_left = data;
			REG_TOP:      mask_regs.region_top = data;
			REG_RIGHT:    mask_regs.region_right = data;
			REG_BOTTOM:   mask_regs.region_bottom = data;
			default: ;
		endcase
	endtask

	task automatic program_regs(input int inv, input int opac, input int width,
			input int height, input int left, input int top, input int right,
			input int bottom);
		write_reg(REG_INVERSE, CFG_W'(inv));
		write_reg(REG_OUT_OPAC, CFG_W'(opac));
		write_reg(REG_WIDTH, CFG_W'(width));
		write_reg(REG_HEIGHT, CFG_W'(height));
		write_reg(REG_LEFT, CFG_W'(left));
		write_reg(REG_TOP, CFG_W'(top));
		write_reg(REG_RIGHT, CFG_W'(right));
		write_reg(REG_BOTTOM, CFG_W'(bottom));
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic feed(input int src, input int prev);
		pending_pixels.push_back(pixel_t'({8'(src), 8'(prev)}));
	endtask

	task automatic random_pixels(input int n);
		int sel;
		int src;
		int prev;
		for (int i = 0; i < n; i++) begin
			sel = $urandom_range(9);
			src = sel == 0 ? 0 : sel == 1 ? 255 : $urandom_range(255);
			sel = $urandom_range(9);
			prev = sel == 0 ? 0 : sel == 1 ? 255 : $urandom_range(255);
			feed(src, prev);
		end
	endtask

	task automatic drain();
		while (pending_pixels.size() != 0 || in_ch.valid || expected_words.size() != 0)
			@(negedge clk);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	task automatic random_setup();
		int sel;
		int opac;
		int width;
		int height;
		int offs [2];
		int lims [2];
		sel = $urandom_range(3);
		opac = sel == 0 ? 0 : sel == 1 ? 255 : $urandom_range(255);
		sel = $urandom_range(9);
		width = sel == 0 ? 0 : sel == 1 ? $urandom_range(8191, 4097) : $urandom_range(12, 1);
		sel = $urandom_range(9);
		height = sel == 0 ? 0 : sel == 1 ? $urandom_range(8191, 4097) : $urandom_range(6, 1);
		for (int i = 0; i < 2; i++) begin
			sel = $urandom_range(9);
			offs[i] = sel == 0 ? -8192 : sel == 1 ? 8191 : int'($urandom_range(16)) - 8;
			sel = $urandom_range(9);
			lims[i] = sel == 0 ? 8191 : sel == 1 ? -8192 : sel == 2 ? -1 :
				int'($urandom_range(16)) - 2;
		end
		// junk in the bits above the width of the inverse, opacity, width and height registers
		program_regs($urandom_range(1) | ($urandom_range(8191) << 1),
			opac | ($urandom_range(63) << 8),
			width | ($urandom_range(1) << 13),
			height | ($urandom_range(1) << 13),
			offs[0], offs[1], lims[0], lims[1]);
	endtask

	initial begin
		in_ch.valid = 1'b0;
		in_ch.source_alpha = '0;
		in_ch.prev_alpha = '0;
		out_ch.ready = 1'b0;
		mask_regs = '{inverse: 1'b0, outside_opacity: 8'd255, mask_width: 13'd1,
			mask_height: 13'd1, region_left: '0, region_top: '0, region_right: '1,
			region_bottom: '1};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		set_flow(FLOW_FREE);

		// reset values: empty region, full opacity, 1x1 mask
		feed(0, 0);
		feed(255, 255);
		feed(170, 85);
		drain();

		// 3x2 mask, region covers the first two pixels of row 0
		program_regs(0, 128, 3, 2, 0, 0, 1, 0);
		feed(255, 255);
		feed(255, 0);
		feed(255, 77);
		feed(1, 255);
		feed(128, 128);
		feed(85, 170);
		drain();

		// inverted alpha, zero opacity, mask starts one pixel up and left of the region
		program_regs('h2AAB, 'h3F00, 'h2002, 2, -1, -1, 8191, 8191);
		feed(0, 200);
		feed(255, 200);
		feed(100, 13);
		feed(0, 255);
		drain();

		// zero sizes read as one; far offsets with negative bounds
		program_regs(0, 255, 'h2000, 0, 8191, 8191, -8192, -8192);
		feed(7, 0);
		feed(200, 9);
		drain();

		// shrink the mask while the counters are past the new end
		program_regs(0, 0, 3, 3, 0, 0, 0, 0);
		random_pixels(5);
		drain();
		program_regs(0, 0, 2, 1, 0, 0, 0, 0);
		random_pixels(3);
		drain();

		// oversize width and height saturate to MAX_DIM, so no early row or mask end
		set_flow(FLOW_BOTH);
		program_regs(0, 255, 'h1FFF, 1, 0, 0, -1, -1);
		random_pixels(20);
		drain();
		set_flow(FLOW_FREE);
		program_regs(1, 255, 1, 'h3FFF, 0, 0, -1, -1);
		random_pixels(20);
		drain();

		for (int ph = 0; ph < 14; ph++) begin
			random_setup();
			set_flow(flow_t'(ph % 4));
			random_pixels($urandom_range(52, 32));
			if (ph == 4)
				hold_requests++;
			drain();
		end

		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#2000000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

### stacked_alpha_mask_combine.f
src/sam_pkg.sv
src/sam_if.sv
src/sam_cfg.sv
src/sam_pos.sv
src/sam_blend.sv
src/stacked_alpha_mask_combine.sv
sim/stacked_alpha_mask_combine_test.sv
